[sv/cbez_pkg.sv]
// shared types, op codes and constants for the cubic bezier evaluator
// no dependencies; imported by every module of the block

package cbez_pkg;

    localparam int SAMPLES_DEF = 128;
    localparam int COORD_W     = 24;
    localparam int T_W         = 17;
    localparam int LEN_W       = 32;
    localparam int SQ_W        = 50;
    localparam int ROOT_W      = 26;
    localparam int EVAL_STEPS  = 15;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    // datapath operations, issued one per cycle by the controller, OP_NOP while it waits
    localparam logic [4:0] OP_NOP        = 5'd0;
    localparam logic [4:0] OP_LOAD_T     = 5'd1;
    localparam logic [4:0] OP_MEAS_INIT  = 5'd2;
    localparam logic [4:0] OP_MUL_UU     = 5'd3;
    localparam logic [4:0] OP_MUL_TT     = 5'd4;
    localparam logic [4:0] OP_MUL_W0     = 5'd5;
    localparam logic [4:0] OP_MUL_W1     = 5'd6;
    localparam logic [4:0] OP_MUL_W2     = 5'd7;
    localparam logic [4:0] OP_MUL_W3     = 5'd8;
    localparam logic [4:0] OP_MUL_X0     = 5'd9;
    localparam logic [4:0] OP_MUL_X1     = 5'd10;
    localparam logic [4:0] OP_MUL_X2     = 5'd11;
    localparam logic [4:0] OP_MUL_X3     = 5'd12;
    localparam logic [4:0] OP_MUL_Y0     = 5'd13;
    localparam logic [4:0] OP_MUL_Y1     = 5'd14;
    localparam logic [4:0] OP_MUL_Y2     = 5'd15;
    localparam logic [4:0] OP_MUL_Y3     = 5'd16;
    localparam logic [4:0] OP_ROUND      = 5'd17;
    localparam logic [4:0] OP_SEG_DIFF   = 5'd18;
    localparam logic [4:0] OP_MUL_DX     = 5'd19;
    localparam logic [4:0] OP_MUL_DY     = 5'd20;
    localparam logic [4:0] OP_SQRT_START = 5'd21;
    localparam logic [4:0] OP_SUM        = 5'd22;
    localparam logic [4:0] OP_NEXT_T     = 5'd23;
    localparam logic [4:0] OP_STORE      = 5'd24;
    localparam logic [4:0] OP_OUT_EVAL   = 5'd25;
    localparam logic [4:0] OP_OUT_MEAS   = 5'd26;
    localparam logic [4:0] OP_SAVE_P     = 5'd27;

    localparam logic [2:0] REG_START_X = 3'd0;
    localparam logic [2:0] REG_START_Y = 3'd1;
    localparam logic [2:0] REG_CTRL1_X = 3'd2;
    localparam logic [2:0] REG_CTRL1_Y = 3'd3;
    localparam logic [2:0] REG_CTRL2_X = 3'd4;
    localparam logic [2:0] REG_CTRL2_Y = 3'd5;
    localparam logic [2:0] REG_END_X   = 3'd6;
    localparam logic [2:0] REG_END_Y   = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] ctrl1_x;
        logic signed [COORD_W-1:0] ctrl1_y;
        logic signed [COORD_W-1:0] ctrl2_x;
        logic signed [COORD_W-1:0] ctrl2_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } bez_pts_t;

    typedef struct packed {
        logic [4:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic sqrt_done;
    } dp_status_t;

endpackage

[sv/cbez_sqrt.sv]
// iterative square root, two radicand bits per cycle, rounded to nearest
// depends on cbez_pkg

module cbez_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cbez_pkg::SQ_W-1:0]   value,
    output logic                        done,
    output logic [cbez_pkg::ROOT_W-1:0] root
);
    import cbez_pkg::*;

    localparam int STEPS = SQ_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]  val_reg;
    logic [STEPS-1:0] res_reg;
    logic [STEPS+1:0] rem_reg;
    logic [STEPS+3:0] rem_sh, trial;
    logic             fits;

    // shift in the next bit pair and try to subtract 4*root+1
    assign rem_sh = {rem_reg, val_reg[SQ_W-1 -: 2]};
    assign trial  = {2'b00, res_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= value;
            res_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= {val_reg[SQ_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg <= (STEPS+2)'(rem_sh - trial);
                res_reg <= {res_reg[STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= (STEPS+2)'(rem_sh);
                res_reg <= {res_reg[STEPS-2:0], 1'b0};
            end
        end
    end

    // round up when the remainder exceeds the floor root
    assign done = done_reg;
    assign root = ROOT_W'(res_reg) + ROOT_W'(rem_reg > (STEPS+2)'(res_reg));

endmodule

[sv/cbez_datapath.sv]
// datapath: shared multiplier, weight and accumulator registers, length sum
// depends on cbez_pkg and cbez_sqrt

module cbez_datapath #(
    parameter int SAMPLES = cbez_pkg::SAMPLES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cbez_pkg::dp_cmd_t                  cmd,
    output cbez_pkg::dp_status_t               status,
    input  cbez_pkg::bez_pts_t                 pts,
    input  logic [cbez_pkg::T_W-1:0]           t_value,
    output logic signed [cbez_pkg::COORD_W-1:0] point_x,
    output logic signed [cbez_pkg::COORD_W-1:0] point_y,
    output logic [cbez_pkg::LEN_W-1:0]         arc_length
);
    import cbez_pkg::*;

    localparam int T_STEP = 65536 / SAMPLES;
    localparam int T_REM  = 65536 % SAMPLES;
    localparam int REM_W  = $clog2(SAMPLES) + 1;

    logic [T_W-1:0]          t_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [33:0]             uu_reg, tt_reg;
    logic [32:0]             w_reg [4];
    logic signed [63:0]      acc_x_reg, acc_y_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, xp_reg, yp_reg;
    logic signed [COORD_W:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [LEN_W-1:0]        sum_reg;
    logic [LEN_W-1:0]        stored_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [LEN_W-1:0]        out_len_reg;

    logic [T_W-1:0]          u_val;
    logic signed [34:0]      mul_a;
    logic signed [26:0]      mul_b;
    logic signed [61:0]      prod;
    logic [49:0]             w_round;
    logic [1:0]              w_sel;
    logic signed [COORD_W-1:0] coord;
    logic                    inner;
    logic signed [25:0]      c_ext, p_val;
    logic signed [63:0]      rx, ry;
    logic signed [COORD_W-1:0] sat_x, sat_y;
    logic [REM_W-1:0]        rem_n;
    logic [LEN_W:0]          sum_n;
    logic                    sq_done;
    logic [ROOT_W-1:0]       root;

    assign u_val = T_ONE - t_reg;

    // control point for the current product, inner points tripled
    always_comb
    begin
        coord = pts.start_x;
        inner = 1'b0;
        w_sel = 2'd0;
        case (cmd.op)
            OP_MUL_X0: begin coord = pts.start_x; w_sel = 2'd0; end
            OP_MUL_X1: begin coord = pts.ctrl1_x; w_sel = 2'd1; inner = 1'b1; end
            OP_MUL_X2: begin coord = pts.ctrl2_x; w_sel = 2'd2; inner = 1'b1; end
            OP_MUL_X3: begin coord = pts.end_x;   w_sel = 2'd3; end
            OP_MUL_Y0: begin coord = pts.start_y; w_sel = 2'd0; end
            OP_MUL_Y1: begin coord = pts.ctrl1_y; w_sel = 2'd1; inner = 1'b1; end
            OP_MUL_Y2: begin coord = pts.ctrl2_y; w_sel = 2'd2; inner = 1'b1; end
            OP_MUL_Y3: begin coord = pts.end_y;   w_sel = 2'd3; end
            default:   begin coord = pts.start_x; w_sel = 2'd0; end
        endcase
    end

    assign c_ext = {{2{coord[COORD_W-1]}}, coord};
    assign p_val = inner ? c_ext + (c_ext <<< 1) : c_ext;

    // operand select for the one shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_UU: begin mul_a = {18'b0, u_val};  mul_b = {10'b0, u_val}; end
            OP_MUL_TT: begin mul_a = {18'b0, t_reg};  mul_b = {10'b0, t_reg}; end
            OP_MUL_W0: begin mul_a = {1'b0, uu_reg};  mul_b = {10'b0, u_val}; end
            OP_MUL_W1: begin mul_a = {1'b0, uu_reg};  mul_b = {10'b0, t_reg}; end
            OP_MUL_W2: begin mul_a = {1'b0, tt_reg};  mul_b = {10'b0, u_val}; end
            OP_MUL_W3: begin mul_a = {1'b0, tt_reg};  mul_b = {10'b0, t_reg}; end
            OP_MUL_X0, OP_MUL_X1, OP_MUL_X2, OP_MUL_X3,
            OP_MUL_Y0, OP_MUL_Y1, OP_MUL_Y2, OP_MUL_Y3:
            begin
                mul_a = {2'b0, w_reg[w_sel]};
                mul_b = {p_val[25], p_val};
            end
            OP_MUL_DX:
            begin
                mul_a = {{10{dx_reg[COORD_W]}}, dx_reg};
                mul_b = {{2{dx_reg[COORD_W]}}, dx_reg};
            end
            OP_MUL_DY:
            begin
                mul_a = {{10{dy_reg[COORD_W]}}, dy_reg};
                mul_b = {{2{dy_reg[COORD_W]}}, dy_reg};
            end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign w_round = {1'b0, prod[48:0]} + 50'd32768;

    // round half up at 2^-32 then clamp to the coordinate range
    assign rx = (acc_x_reg + 64'sd2147483648) >>> 32;
    assign ry = (acc_y_reg + 64'sd2147483648) >>> 32;

    always_comb
    begin
        if (rx > 64'sd8388607)
            sat_x = 24'sh7FFFFF;
        else if (rx < -64'sd8388608)
            sat_x = 24'sh800000;
        else
            sat_x = rx[COORD_W-1:0];
        if (ry > 64'sd8388607)
            sat_y = 24'sh7FFFFF;
        else if (ry < -64'sd8388608)
            sat_y = 24'sh800000;
        else
            sat_y = ry[COORD_W-1:0];
    end

    assign rem_n = rem_reg + REM_W'(T_REM);
    assign sum_n = {1'b0, sum_reg} + (LEN_W+1)'(root);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD_T:    t_reg <= (t_value > T_ONE) ? T_ONE : t_value;
            OP_MEAS_INIT:
            begin
                t_reg   <= '0;
                rem_reg <= '0;
                sum_reg <= '0;
            end
            OP_MUL_UU:    uu_reg <= prod[33:0];
            OP_MUL_TT:    tt_reg <= prod[33:0];
            OP_MUL_W0:    w_reg[0] <= w_round[48:16];
            OP_MUL_W1:    w_reg[1] <= w_round[48:16];
            OP_MUL_W2:    w_reg[2] <= w_round[48:16];
            OP_MUL_W3:    w_reg[3] <= w_round[48:16];
            OP_MUL_X0:    acc_x_reg <= {{2{prod[61]}}, prod};
            OP_MUL_X1, OP_MUL_X2, OP_MUL_X3:
                          acc_x_reg <= acc_x_reg + {{2{prod[61]}}, prod};
            OP_MUL_Y0:    acc_y_reg <= {{2{prod[61]}}, prod};
            OP_MUL_Y1, OP_MUL_Y2, OP_MUL_Y3:
                          acc_y_reg <= acc_y_reg + {{2{prod[61]}}, prod};
            OP_ROUND:
            begin
                px_reg <= sat_x;
                py_reg <= sat_y;
            end
            OP_SAVE_P:
            begin
                xp_reg <= px_reg;
                yp_reg <= py_reg;
            end
            OP_SEG_DIFF:
            begin
                dx_reg <= {px_reg[COORD_W-1], px_reg} - {xp_reg[COORD_W-1], xp_reg};
                dy_reg <= {py_reg[COORD_W-1], py_reg} - {yp_reg[COORD_W-1], yp_reg};
                xp_reg <= px_reg;
                yp_reg <= py_reg;
            end
            OP_MUL_DX:    sq_reg <= prod[SQ_W-1:0];
            OP_MUL_DY:    sq_reg <= sq_reg + prod[SQ_W-1:0];
            OP_SUM:       sum_reg <= sum_n[LEN_W] ? '1 : sum_n[LEN_W-1:0];
            OP_NEXT_T:
            begin
                // exact floor(i*65536/SAMPLES) by quotient and remainder steps
                if (rem_n >= REM_W'(SAMPLES))
                begin
                    t_reg   <= t_reg + T_W'(T_STEP + 1);
                    rem_reg <= rem_n - REM_W'(SAMPLES);
                end
                else
                begin
                    t_reg   <= t_reg + T_W'(T_STEP);
                    rem_reg <= rem_n;
                end
            end
            OP_OUT_EVAL:
            begin
                out_x_reg   <= px_reg;
                out_y_reg   <= py_reg;
                out_len_reg <= stored_reg;
            end
            OP_OUT_MEAS:
            begin
                out_x_reg   <= '0;
                out_y_reg   <= '0;
                out_len_reg <= stored_reg;
            end
            default:      t_reg <= t_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stored_reg <= '0;
        else if (cmd.op == OP_STORE)
            stored_reg <= sum_reg;
    end

    cbez_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_SQRT_START),
        .value (sq_reg),
        .done  (sq_done),
        .root  (root)
    );

    assign status.sqrt_done = sq_done;
    assign point_x    = out_x_reg;
    assign point_y    = out_y_reg;
    assign arc_length = out_len_reg;

endmodule

[sv/cbez_ctrl.sv]
// controller state machine: sequences datapath ops and runs both handshakes
// depends on cbez_pkg

module cbez_ctrl #(
    parameter int SAMPLES = cbez_pkg::SAMPLES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cbez_pkg::dp_cmd_t     cmd,
    input  cbez_pkg::dp_status_t  status
);
    import cbez_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EVAL = 4'd1;
    localparam logic [3:0] S_SAVE = 4'd2;
    localparam logic [3:0] S_SEG  = 4'd3;
    localparam logic [3:0] S_SQX  = 4'd4;
    localparam logic [3:0] S_SQY  = 4'd5;
    localparam logic [3:0] S_SQST = 4'd6;
    localparam logic [3:0] S_SQW  = 4'd7;
    localparam logic [3:0] S_ADV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [3:0]       step_reg, step_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             meas_reg, meas_next;
    logic             ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        meas_next  = meas_reg;
        ov_next    = ov_reg;
        cmd.op     = OP_NOP;
        in_ready   = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = command ? OP_MEAS_INIT : OP_LOAD_T;
                    meas_next  = command;
                    idx_next   = '0;
                    step_next  = '0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.op    = OP_MUL_UU + {1'b0, step_reg};
                step_next = step_reg + 1'b1;
                if (step_reg == 4'(EVAL_STEPS - 1))
                begin
                    if (!meas_reg)
                        state_next = S_OUT;
                    else if (idx_reg == '0)
                        state_next = S_SAVE;
                    else
                        state_next = S_SEG;
                end
            end
            S_SAVE:
            begin
                cmd.op     = OP_SAVE_P;
                state_next = S_ADV;
            end
            S_SEG:
            begin
                cmd.op     = OP_SEG_DIFF;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                cmd.op     = OP_MUL_DX;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.op     = OP_MUL_DY;
                state_next = S_SQST;
            end
            S_SQST:
            begin
                cmd.op     = OP_SQRT_START;
                state_next = S_SQW;
            end
            S_SQW:
            begin
                if (status.sqrt_done)
                begin
                    cmd.op     = OP_SUM;
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                if (idx_reg == CNT_W'(SAMPLES))
                begin
                    cmd.op     = OP_STORE;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = OP_NEXT_T;
                    idx_next   = idx_reg + 1'b1;
                    step_next  = '0;
                    state_next = S_EVAL;
                end
            end
            S_OUT:
            begin
                // load the output register once it is free or being emptied
                if (!ov_reg || out_ready)
                begin
                    cmd.op     = meas_reg ? OP_OUT_MEAS : OP_OUT_EVAL;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
            meas_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            meas_reg  <= meas_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

[sv/cubic_bezier_eval_and_length_unit.sv]
// top level of the cubic bezier evaluator and arc-length unit
// depends on cbez_pkg, cbez_ctrl, cbez_datapath (and cbez_sqrt below it)

// Four control points are held in eight 24-bit signed Q15.8 registers on
// an APB-style port (register i at byte address 4*i, reads sign-extended
// to 32 bits, pready always high). An input transfer with command 0
// evaluates the Bernstein form at t_value (Q1.16, values above 1.0 clamp
// to 1.0) and returns point_x/point_y, rounded half up and clamped. An
// input transfer with command 1 walks the curve at SAMPLES+1 points,
// sums the rounded segment lengths with saturation, stores the sum and
// returns zero coordinates. Every result carries the stored length.
// All products go through one shared multiplier, so an evaluate runs the
// accept step, 15 multiplier and rounding steps and the output load in
// that order. The run of a measure is set by the shared multiplier (15
// steps per sample point) and the two-bits-per-cycle square root (25
// steps per segment). The block takes one item at a time; the output
// register lets a new item be accepted while the previous result is
// still waiting.

module cubic_bezier_eval_and_length_unit #(
    parameter int SAMPLES = cbez_pkg::SAMPLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [cbez_pkg::T_W-1:0]            t_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cbez_pkg::COORD_W-1:0] point_x,
    output logic signed [cbez_pkg::COORD_W-1:0] point_y,
    output logic [cbez_pkg::LEN_W-1:0]          arc_length,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import cbez_pkg::*;

    logic signed [COORD_W-1:0] cfg_reg [8];
    logic [2:0]                cfg_idx;
    bez_pts_t                  pts;
    dp_cmd_t                   dp_cmd;
    dp_status_t                dp_status;

    // register write on the access phase of an apb transfer
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                cfg_reg[i] <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            cfg_reg[cfg_idx] <= pwdata[COORD_W-1:0];
        end
    end

    assign prdata = {{(32-COORD_W){cfg_reg[cfg_idx][COORD_W-1]}}, cfg_reg[cfg_idx]};

    assign pts.start_x = cfg_reg[REG_START_X];
    assign pts.start_y = cfg_reg[REG_START_Y];
    assign pts.ctrl1_x = cfg_reg[REG_CTRL1_X];
    assign pts.ctrl1_y = cfg_reg[REG_CTRL1_Y];
    assign pts.ctrl2_x = cfg_reg[REG_CTRL2_X];
    assign pts.ctrl2_y = cfg_reg[REG_CTRL2_Y];
    assign pts.end_x   = cfg_reg[REG_END_X];
    assign pts.end_y   = cfg_reg[REG_END_Y];

    // sequencer: one datapath op per cycle, a no-op while it waits
    cbez_ctrl #(
        .SAMPLES (SAMPLES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    // multiplier, accumulators, square root and output register
    cbez_datapath #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .status     (dp_status),
        .pts        (pts),
        .t_value    (t_value),
        .point_x    (point_x),
        .point_y    (point_y),
        .arc_length (arc_length)
    );

    // an accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous item still in progress");

    // a result only appears out of a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised without any work in progress");

endmodule

[dv/cubic_bezier_eval_and_length_unit_tb.sv]
// testbench for the cubic bezier evaluator and arc-length unit
// depends on cbez_pkg and cubic_bezier_eval_and_length_unit; self-checking

module cubic_bezier_eval_and_length_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cbez_pkg::*;

    localparam int NUM_SAMPLES = 128;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int MEAS_LAT = 46 * NUM_SAMPLES + 60;

    typedef struct {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [31:0]        len;
    } bez_result_t;

    // shadow of the control points and a bit-accurate curve model
    class bezier_scoreboard;
        logic signed [23:0] pts[8];
        logic [31:0]        stored_len;
        bez_result_t        pending[$];
        int                 errors;

        function new();
            foreach (pts[i]) pts[i] = '0;
            stored_len = '0;
            errors = 0;
        endfunction

        // one axis of the curve at t, rounded half up and clamped
        function logic signed [23:0] axis_at(int base, logic [16:0] t);
            longint unsigned tt, u, w0, w1, w2, w3;
            longint s, r;
            tt = t;
            u = 65536 - tt;
            w0 = (u * u * u + 32768) >> 16;
            w1 = (u * u * tt + 32768) >> 16;
            w2 = (u * tt * tt + 32768) >> 16;
            w3 = (tt * tt * tt + 32768) >> 16;
            s = longint'(pts[base]) * longint'(w0)
              + 3 * longint'(pts[base + 2]) * longint'(w1)
              + 3 * longint'(pts[base + 4]) * longint'(w2)
              + longint'(pts[base + 6]) * longint'(w3);
            r = (s + (longint'(1) << 31)) >>> 32;
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
            return r[23:0];
        endfunction

        function longint unsigned root_nearest(longint unsigned v);
            longint unsigned res, bitv, x;
            res = 0;
            bitv = longint'(1) << 62;
            x = v;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            if (res * res + res < v) res++;
            return res;
        endfunction

        function logic [31:0] polyline_length();
            longint unsigned total;
            longint xp, yp, x, y, dx, dy;
            logic [16:0] t;
            total = 0;
            xp = axis_at(0, 0);
            yp = axis_at(1, 0);
            for (int i = 1; i <= NUM_SAMPLES; i++)
            begin
                t = 17'((i * 65536) / NUM_SAMPLES);
                x = axis_at(0, t);
                y = axis_at(1, t);
                dx = x - xp;
                dy = y - yp;
                total += root_nearest(longint'(dx * dx) + longint'(dy * dy));
                if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
                xp = x;
                yp = y;
            end
            return total[31:0];
        endfunction

        function void note_input(logic cmd, logic [16:0] t);
            bez_result_t e;
            if (cmd == 1'b0)
            begin
                if (t > T_ONE) t = T_ONE;
                e.px = axis_at(0, t);
                e.py = axis_at(1, t);
            end
            else
            begin
                stored_len = polyline_length();
                e.px = '0;
                e.py = '0;
            end
            e.len = stored_len;
            pending.push_back(e);
        endfunction

        function void check_result(logic signed [23:0] px, logic signed [23:0] py,
                                   logic [31:0] len);
            bez_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d len=%0d", $time, px, py, len);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (px !== e.px)
            begin
                $display("%0t: point_x expected %0d actual %0d", $time, e.px, px);
                errors++;
            end
            if (py !== e.py)
            begin
                $display("%0t: point_y expected %0d actual %0d", $time, e.py, py);
                errors++;
            end
            if (len !== e.len)
            begin
                $display("%0t: arc_length expected %0d actual %0d", $time, e.len, len);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = 1'b0;
    logic [16:0] t_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [23:0] point_x, point_y;
    logic [31:0] arc_length;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bezier_scoreboard sb = new();
    int  send_idle_pct = 0;   // chance per cycle that the sender holds off
    int  recv_stall_pct = 0;  // chance per cycle that the receiver stalls
    int  idle_cycles = 0;
    bit  done = 1'b0;

    always #5 clk = ~clk;

    cubic_bezier_eval_and_length_unit DUT (.*);

    // score every transfer on the rising edge
    always @(posedge clk)
    begin
        if (in_valid && in_ready) sb.note_input(command, t_value);
        if (out_valid && out_ready) sb.check_result(point_x, point_y, arc_length);
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if (!done && idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // register write with a setup and an access phase; only called while the block is idle
    task automatic reg_write(logic [2:0] idx, logic signed [23:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {{8{val[23]}}, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.pts[idx] = val;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // one input transfer, with random hold-off before it; called and
    // returning on a falling edge, valid stays up until the caller or the next call lowers it
    task automatic send_item(logic cmd, logic [16:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        t_value <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // wait for the scoreboard to drain, then idle before returning
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic load_curve(logic signed [23:0] v[8]);
        for (int i = 0; i < 8; i++) reg_write(i[2:0], v[i]);
    endtask

    function automatic logic signed [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom());
            1: return $signed(24'($urandom_range(4000))) - 24'sd2000;
            2: return ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
            default: return $signed(24'($urandom_range(200000))) - 24'sd100000;
        endcase
    endfunction

    function automatic logic [16:0] rand_t();
        case ($urandom_range(9))
            0: return T_ONE;
            1: return 17'($urandom_range(131071, 65537));  // clamps to one
            2: return 17'($urandom_range(15));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    initial
    begin
        logic signed [23:0] curve[8];
        int phase_items;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset curve: all zeros, measure gives zero
        send_item(1'b0, 17'd32768);
        send_item(1'b1, 17'd0);
        drain();

        // extreme points drive the rounding clamp
        curve = '{24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000,
                  24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000};
        load_curve(curve);
        send_item(1'b0, 17'd0);
        send_item(1'b0, T_ONE);
        send_item(1'b0, 17'h1FFFF);
        send_item(1'b0, 17'd1);
        send_item(1'b0, 17'd32768);
        send_item(1'b0, 17'd21845);
        send_item(1'b1, 17'h1FFFF);
        send_item(1'b0, 17'd43690);
        drain();

        // stored length survives register writes until the next measure
        curve = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                  24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000};
        load_curve(curve);
        send_item(1'b0, 17'd65535);
        send_item(1'b0, 17'd12345);
        send_item(1'b1, 17'd5);
        send_item(1'b0, 17'd100);
        drain();

        // random phases with different idling mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int i = 0; i < 8; i++) curve[i] = rand_coord((ph + i) % 4);
            load_curve(curve);
            phase_items = 80;
            for (int k = 0; k < phase_items; k++)
            begin
                // measures are slow; keep them to a few per phase
                send_item(($urandom_range(39) == 0) ? 1'b1 : 1'b0, rand_t());
                // sender waits for every pending result once per phase
                if (k == phase_items / 2)
                begin
                    in_valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge clk);
                    @(negedge clk);
                end
            end
            send_item(1'b1, 17'($urandom()));
            drain();
        end

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (MEAS_LAT / 100) @(posedge clk);
        done = 1'b1;
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
